FILE: hw/rtl/itp_pkg.sv
// shared constants, codes and helper functions of the infix to postfix converter
package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int CODE_W      = 3;
  localparam int CHAR_W      = 8;
  localparam int ERR_W       = 2;

  // ascii characters of interest
  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_TIMES = 8'h2a;
  localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2f;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

  // stack entry codes
  localparam logic [CODE_W-1:0] CODE_OPEN  = 3'd0;
  localparam logic [CODE_W-1:0] CODE_PLUS  = 3'd1;
  localparam logic [CODE_W-1:0] CODE_MINUS = 3'd2;
  localparam logic [CODE_W-1:0] CODE_TIMES = 3'd3;
  localparam logic [CODE_W-1:0] CODE_DIV   = 3'd4;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [ERR_W-1:0] ERR_UNMATCH  = 2'd2;

  // request classes
  typedef logic [2:0] cls_t;
  localparam cls_t CLS_IGNORE = 3'd0;
  localparam cls_t CLS_DIGIT  = 3'd1;
  localparam cls_t CLS_OPEN   = 3'd2;
  localparam cls_t CLS_CLOSE  = 3'd3;
  localparam cls_t CLS_OP     = 3'd4;
  localparam cls_t CLS_END    = 3'd5;

  typedef logic [CODE_W-1:0] code_t;

  function automatic cls_t classify(input logic kind, input logic [CHAR_W-1:0] ch);
    cls_t c;
    c = CLS_IGNORE;
    if (kind) begin
      c = CLS_END;
    end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
      c = CLS_DIGIT;
    end else if (ch == CH_OPEN) begin
      c = CLS_OPEN;
    end else if (ch == CH_CLOSE) begin
      c = CLS_CLOSE;
    end else if (ch == CH_PLUS || ch == CH_MINUS || ch == CH_TIMES || ch == CH_DIV) begin
      c = CLS_OP;
    end
    return c;
  endfunction

  function automatic code_t char_code(input logic [CHAR_W-1:0] ch);
    code_t c;
    c = CODE_OPEN;
    if (ch == CH_PLUS) begin
      c = CODE_PLUS;
    end else if (ch == CH_MINUS) begin
      c = CODE_MINUS;
    end else if (ch == CH_TIMES) begin
      c = CODE_TIMES;
    end else if (ch == CH_DIV) begin
      c = CODE_DIV;
    end
    return c;
  endfunction

  function automatic logic [1:0] prec(input code_t code);
    logic [1:0] p;
    p = 2'd0;
    if (code == CODE_TIMES || code == CODE_DIV) begin
      p = 2'd2;
    end else if (code == CODE_PLUS || code == CODE_MINUS) begin
      p = 2'd1;
    end
    return p;
  endfunction

  function automatic logic [CHAR_W-1:0] code_char(input code_t code);
    logic [CHAR_W-1:0] c;
    c = CH_NONE;
    if (code == CODE_OPEN) begin
      c = CH_OPEN;
    end else if (code == CODE_PLUS) begin
      c = CH_PLUS;
    end else if (code == CODE_MINUS) begin
      c = CH_MINUS;
    end else if (code == CODE_TIMES) begin
      c = CH_TIMES;
    end else if (code == CODE_DIV) begin
      c = CH_DIV;
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/itp_if.sv
// request and result channel interfaces of the infix to postfix converter
interface itp_in_if;
  import itp_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [CHAR_W-1:0] symbol_in;
  modport source (output valid, output kind, output symbol_in, input ready);
  modport sink   (input valid, input kind, input symbol_in, output ready);
endinterface

interface itp_out_if;
  import itp_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] symbol_out;
  logic              has_symbol;
  logic              last;
  logic [ERR_W-1:0]  error;
  modport source (output valid, output symbol_out, output has_symbol, output last,
                  output error, input ready);
  modport sink   (input valid, input symbol_out, input has_symbol, input last,
                  input error, output ready);
endinterface

FILE: hw/rtl/itp_stack_ram.sv
// single port write, single port read synchronous ram for the operator stack
module itp_stack_ram #(
  parameter int DEPTH  = 32,
  parameter int WIDTH  = 3,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/infix_to_postfix_converter.sv
// top level of the shunting-yard infix to postfix converter
// Usage and timing: send one infix character per request (kind = 0) and a
// request with kind = 1 to close the expression; postfix characters come out
// on the result channel, the final result of an end request has last set.
// The operator stack lives in a synchronous ram with registered reads, and
// only the stack count sits in flip-flops, so reset is immediate and no
// clearing pass is needed. A request is taken only while the converter is
// idle. A character that is not a digit, a parenthesis or + - * / is
// absorbed with no result. For any other request the accept cycle starts
// the ram read of the stack top and the next cycle acts on it; each pop
// issues the read of the next entry. A close parenthesis that pops entries
// finishes in the cycle of its final pop (its matching open one, or the
// bottom entry when it runs dry). A result waits in an output register, so
// work goes on while it is still pending and stalls only when a second
// result is ready before the first is taken. A push onto a full stack is
// dropped and reported with error 1, a close parenthesis with no matching
// open one with error 2.
module infix_to_postfix_converter (
  input  logic clk,
  input  logic rst,
  itp_in_if.sink     items,
  itp_out_if.source  results
);
  import itp_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EVAL = 1'b1;

  // control state
  logic               state, state_next;
  logic [COUNT_W-1:0] count, count_next;
  logic               pend_valid, pend_valid_next;

  // held request
  cls_t               cls;
  code_t              opcode;
  logic [CHAR_W-1:0]  sym;
  logic [CHAR_W-1:0]  pend_sym, pend_sym_next;

  // output register
  logic               out_valid;
  logic [CHAR_W-1:0]  out_sym;
  logic               out_has;
  logic               out_last;
  logic [ERR_W-1:0]   out_err;

  // ram ports
  logic               rd_en;
  logic [PTR_W-1:0]   rd_addr;
  logic               wr_en;
  code_t              top;

  // result being produced this cycle
  logic               emit;
  logic [CHAR_W-1:0]  e_sym;
  logic               e_has;
  logic               e_last;
  logic [ERR_W-1:0]   e_err;

  logic               accept;
  logic               slot_free;
  logic               stack_full;
  logic               pop;
  cls_t               in_cls;
  logic [COUNT_W-1:0] cnt_m1, cnt_m2;

  assign accept     = items.valid && items.ready;
  assign items.ready = (state == S_IDLE);
  assign in_cls     = classify(items.kind, items.symbol_in);
  assign slot_free  = !out_valid || results.ready;
  assign stack_full = (count == COUNT_W'(STACK_DEPTH));
  assign cnt_m1     = count - COUNT_W'(1);
  assign cnt_m2     = count - COUNT_W'(2);

  itp_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (CODE_W)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[PTR_W-1:0]),
    .wr_data (opcode),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (top)
  );

  always_comb begin
    state_next      = state;
    count_next      = count;
    pend_valid_next = pend_valid;
    pend_sym_next   = pend_sym;
    rd_en           = 1'b0;
    rd_addr         = cnt_m1[PTR_W-1:0];
    wr_en           = 1'b0;
    pop             = 1'b0;
    emit            = 1'b0;
    e_sym           = CH_NONE;
    e_has           = 1'b0;
    e_last          = 1'b0;
    e_err           = ERR_NONE;

    unique case (state)
      S_IDLE: begin
        // start reading the stack top together with the accept
        if (accept && in_cls != CLS_IGNORE) begin
          state_next = S_EVAL;
          rd_en      = (count != '0);
        end
      end
      S_EVAL: begin
        unique case (cls)
          CLS_DIGIT: begin
            if (slot_free) begin
              emit       = 1'b1;
              e_sym      = sym;
              e_has      = 1'b1;
              state_next = S_IDLE;
            end
          end
          CLS_OPEN, CLS_OP: begin
            if (cls == CLS_OP && count != '0 && top != CODE_OPEN &&
                prec(top) >= prec(opcode)) begin
              // pop an operator of equal or higher precedence
              if (slot_free) begin
                emit  = 1'b1;
                e_sym = code_char(top);
                e_has = 1'b1;
                pop   = 1'b1;
              end
            end else if (stack_full) begin
              // push dropped
              if (slot_free) begin
                emit       = 1'b1;
                e_err      = ERR_OVERFLOW;
                state_next = S_IDLE;
              end
            end else begin
              wr_en      = 1'b1;
              count_next = count + COUNT_W'(1);
              state_next = S_IDLE;
            end
          end
          CLS_CLOSE: begin
            if (count == '0) begin
              // nothing popped and nothing to match
              if (slot_free) begin
                emit       = 1'b1;
                e_err      = ERR_UNMATCH;
                state_next = S_IDLE;
              end
            end else if (top == CODE_OPEN) begin
              count_next = cnt_m1;
              state_next = S_IDLE;
            end else if (slot_free) begin
              emit  = 1'b1;
              e_sym = code_char(top);
              e_has = 1'b1;
              pop   = 1'b1;
              // popping the bottom entry leaves the close unmatched
              if (count == COUNT_W'(1)) begin
                e_err      = ERR_UNMATCH;
                state_next = S_IDLE;
              end
            end
          end
          CLS_END: begin
            // one result is held back so that last lands on the final one
            if (count == '0) begin
              if (slot_free) begin
                emit            = 1'b1;
                e_sym           = pend_valid ? pend_sym : CH_NONE;
                e_has           = pend_valid;
                e_last          = 1'b1;
                pend_valid_next = 1'b0;
                state_next      = S_IDLE;
              end
            end else if (top == CODE_OPEN) begin
              pop = 1'b1;
            end else if (!pend_valid || slot_free) begin
              emit            = pend_valid;
              e_sym           = pend_sym;
              e_has           = pend_valid;
              pend_sym_next   = code_char(top);
              pend_valid_next = 1'b1;
              pop             = 1'b1;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
        // pop the top and fetch the entry below it
        if (pop) begin
          count_next = cnt_m1;
          rd_en      = (cnt_m1 != '0);
          rd_addr    = cnt_m2[PTR_W-1:0];
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_sym <= pend_sym_next;
    if (accept) begin
      cls    <= in_cls;
      opcode <= char_code(items.symbol_in);
      sym    <= items.symbol_in;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_sym  <= e_sym;
      out_has  <= e_has;
      out_last <= e_last;
      out_err  <= e_err;
    end
  end

  assign results.valid      = out_valid;
  assign results.symbol_out = out_sym;
  assign results.has_symbol = out_has;
  assign results.last       = out_last;
  assign results.error      = out_err;

  // stack count stays within the stack
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // no push into a full stack
  a_no_overflow_write: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !stack_full)
    else $error("write to full stack");

  // a pop always has an entry to remove
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty stack");

  // a result is never produced over one that is still pending
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> slot_free)
    else $error("output register overwritten");

  // every request that is not ignored is worked on in the next cycle
  a_accept_eval: assert property (@(posedge clk) disable iff (rst)
    accept && in_cls != CLS_IGNORE |=> state == S_EVAL)
    else $error("accepted request not evaluated");

endmodule
